FILE: sv/bec_pkg.sv
// bec_pkg: shared types, sizes and helpers for the bipartite edge coloring block
// no dependencies
package bec_pkg;

	localparam int VERTICES = 32;
	localparam int COLORS = 16;
	localparam int EDGES = 256;
	localparam int RESULT_CAP = 32;

	localparam int VW = $clog2(VERTICES);
	localparam int CW = $clog2(COLORS);
	localparam int EW = $clog2(EDGES);
	localparam int EVW = EW + 1;
	localparam int NW = $clog2(RESULT_CAP);
	localparam int CVW = CW + 1;
	localparam int EOCW = VW + CW;

	typedef logic [COLORS-1:0] cmask_t;
	typedef logic [VW-1:0] vslot_t;
	typedef logic [EVW-1:0] edge_t;
	typedef logic [CVW-1:0] color_t;

	typedef struct packed {
		vslot_t free_ra_a;
		vslot_t free_ra_b;
		logic free_we;
		vslot_t free_wa;
		cmask_t free_wd;
		logic [EOCW-1:0] eoc_ra;
		logic eoc_we;
		logic [EOCW-1:0] eoc_wa;
		edge_t eoc_wd;
		logic [EW-1:0] ends_ra;
		logic ends_we;
		logic [EW-1:0] ends_wa;
		logic [2*VW-1:0] ends_wd;
	} mem_req_t;

	typedef struct packed {
		cmask_t free_rd_a;
		cmask_t free_rd_b;
		edge_t eoc_rd;
		logic [2*VW-1:0] ends_rd;
	} mem_rsp_t;

	function automatic color_t lowest(input cmask_t m);
		color_t r;
		r = '0;
		for (int i = COLORS - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = CVW'(i + 1);
			end
		end
		return r;
	endfunction

	function automatic cmask_t cbit(input color_t c);
		cmask_t r;
		r = cmask_t'(1) << CW'(c - color_t'(1));
		return r;
	endfunction

	function automatic logic [EOCW-1:0] cell_addr(input vslot_t w, input color_t c);
		logic [CW-1:0] ci;
		ci = CW'(c - color_t'(1));
		return {w, ci};
	endfunction

endpackage

FILE: sv/bipartite_edge_coloring.sv
// bipartite_edge_coloring: top level, colors one edge per transaction
// depends on bec_pkg, bec_mem and bec_ctrl
// After reset the block clears its tables with busy high. A transaction is taken when start
// is high and busy is low. An edge with a color free at both ends gives one result, and so
// does an overflow, which sets degree_overflow. Otherwise the alternating path is walked one
// path edge at a time through the color-to-edge table, which has one read port, giving k
// results (k at most 32), and busy stays high until the path walk and the repairs are done.
// Each result is flagged by result_strobe high for one cycle; the receiver cannot stall it.
module bipartite_edge_coloring import bec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [8:0] edge_id,
	input  logic [5:0] left_vertex,
	input  logic [5:0] right_vertex,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	output logic       result_strobe,
	output logic [8:0] out_edge,
	output logic [4:0] color,
	output logic       last,
	output logic       degree_overflow
);

	mem_req_t req;
	mem_rsp_t rsp;

	bec_mem u_mem (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	bec_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.edge_id         (edge_id),
		.left_vertex     (left_vertex),
		.right_vertex    (right_vertex),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.result_strobe   (result_strobe),
		.out_edge        (out_edge),
		.color           (color),
		.last            (last),
		.degree_overflow (degree_overflow),
		.req             (req),
		.rsp             (rsp)
	);

endmodule

FILE: sv/bec_mem.sv
// bec_mem: free-color masks, color-to-edge table and edge endpoint store
// depends on bec_pkg; synchronous memories with registered reads
module bec_mem import bec_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	cmask_t free_mem [VERTICES];
	edge_t eoc_mem [VERTICES*COLORS];
	logic [2*VW-1:0] ends_mem [EDGES];

	always_ff @(posedge clk) begin
		if (req.free_we) begin
			free_mem[req.free_wa] <= req.free_wd;
		end
		if (req.eoc_we) begin
			eoc_mem[req.eoc_wa] <= req.eoc_wd;
		end
		if (req.ends_we) begin
			ends_mem[req.ends_wa] <= req.ends_wd;
		end
		rsp.free_rd_a <= free_mem[req.free_ra_a];
		rsp.free_rd_b <= free_mem[req.free_ra_b];
		rsp.eoc_rd <= eoc_mem[req.eoc_ra];
		rsp.ends_rd <= ends_mem[req.ends_ra];
	end

endmodule

FILE: sv/bec_ctrl.sv
// bec_ctrl: sequencer for color choice, alternating path walk and state repair
// depends on bec_pkg; drives bec_mem through mem_req_t / mem_rsp_t
module bec_ctrl import bec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [8:0] edge_id,
	input  logic [5:0] left_vertex,
	input  logic [5:0] right_vertex,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	output logic       result_strobe,
	output logic [8:0] out_edge,
	output logic [4:0] color,
	output logic       last,
	output logic       degree_overflow,
	output mem_req_t   req,
	input  mem_rsp_t   rsp
);

	typedef enum logic [11:0] {
		ST_CLR   = 12'b0000_0000_0001,
		ST_IDLE  = 12'b0000_0000_0010,
		ST_FREE  = 12'b0000_0000_0100,
		ST_COM2  = 12'b0000_0000_1000,
		ST_PRD   = 12'b0000_0001_0000,
		ST_PCHK  = 12'b0000_0010_0000,
		ST_PPT2  = 12'b0000_0100_0000,
		ST_FIN2  = 12'b0000_1000_0000,
		ST_FV    = 12'b0001_0000_0000,
		ST_RW    = 12'b0010_0000_0000,
		ST_FW    = 12'b0100_0000_0000,
		ST_SPARE = 12'b1000_0000_0000
	} state_t;

	state_t state_q;
	logic [4:0] max_degree_q;
	logic [EOCW-1:0] clr_q;
	edge_t e_q, f_q, ff_q;
	vslot_t u_q, v_q, w_q, fl_q, fr_q;
	cmask_t use_q, fu_q, fv_q;
	color_t cu_q, cv_q, c_q;
	logic [NW-1:0] n_q;

	logic [EW-1:0] in_eidx;
	edge_t in_e;
	vslot_t in_u, in_v;
	color_t dclamp;
	cmask_t in_use, fu_m, fv_m, common, fw_m;
	color_t c_com, cu_n, cv_n, c_next, old_c;
	vslot_t lv, rv, w_next;
	logic emit;
	edge_t emit_edge;
	color_t emit_color;
	logic emit_last, emit_ovf;

	assign in_eidx = EW'(edge_id - 9'd1);
	assign in_e = {1'b0, in_eidx} + edge_t'(1);
	assign in_u = VW'(left_vertex - 6'd1);
	assign in_v = VW'(right_vertex - 6'd1);

	always_comb begin
		if (max_degree_q == 5'd0) begin
			dclamp = color_t'(1);
		end else if (max_degree_q > 5'(COLORS)) begin
			dclamp = color_t'(COLORS);
		end else begin
			dclamp = color_t'(max_degree_q);
		end
		in_use = {COLORS{1'b1}} >> (COLORS - int'(dclamp));
	end

	assign fu_m = rsp.free_rd_a & use_q;
	assign fv_m = rsp.free_rd_b & use_q;
	assign common = fu_m & fv_m;
	assign c_com = lowest(common);
	assign cu_n = lowest(fu_m);
	assign cv_n = lowest(fv_m);
	assign c_next = (c_q == cu_q) ? cv_q : cu_q;
	assign old_c = c_next;
	assign lv = rsp.ends_rd[2*VW-1:VW];
	assign rv = rsp.ends_rd[VW-1:0];
	assign w_next = (lv == w_q) ? rv : lv;

	always_comb begin
		fw_m = rsp.free_rd_a & ~cbit(c_q);
		if (f_q != e_q && rsp.eoc_rd == f_q) begin
			fw_m = fw_m | cbit(old_c);
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		req = '0;
		req.free_ra_a = u_q;
		req.free_ra_b = v_q;
		req.eoc_ra = cell_addr(w_q, c_q);
		req.ends_ra = EW'(ff_q - edge_t'(1));
		emit = 1'b0;
		emit_edge = f_q;
		emit_color = c_q;
		emit_last = 1'b0;
		emit_ovf = 1'b0;
		case (state_q)
			ST_CLR: begin
				req.eoc_we = 1'b1;
				req.eoc_wa = clr_q;
				req.eoc_wd = '0;
				req.free_we = 1'b1;
				req.free_wa = clr_q[VW-1:0];
				req.free_wd = '1;
			end
			ST_IDLE: begin
				req.free_ra_a = in_u;
				req.free_ra_b = in_v;
			end
			ST_FREE: begin
				if (fu_m == '0 || fv_m == '0) begin
					emit = 1'b1;
					emit_edge = e_q;
					emit_color = '0;
					emit_last = 1'b1;
					emit_ovf = 1'b1;
				end else begin
					req.ends_we = 1'b1;
					req.ends_wa = EW'(e_q - edge_t'(1));
					req.ends_wd = {u_q, v_q};
					if (common != '0) begin
						req.free_we = 1'b1;
						req.free_wa = u_q;
						req.free_wd = rsp.free_rd_a & ~cbit(c_com);
						req.eoc_we = 1'b1;
						req.eoc_wa = cell_addr(u_q, c_com);
						req.eoc_wd = e_q;
						emit = 1'b1;
						emit_edge = e_q;
						emit_color = c_com;
						emit_last = 1'b1;
					end
				end
			end
			ST_COM2: begin
				req.free_we = 1'b1;
				req.free_wa = v_q;
				req.free_wd = fv_q & ~cbit(c_q);
				req.eoc_we = 1'b1;
				req.eoc_wa = cell_addr(v_q, c_q);
				req.eoc_wd = e_q;
			end
			ST_PCHK: begin
				req.eoc_we = 1'b1;
				req.eoc_wa = cell_addr(fl_q, c_q);
				req.eoc_wd = f_q;
				req.ends_ra = EW'(rsp.eoc_rd - edge_t'(1));
				emit = 1'b1;
				emit_last = !(rsp.eoc_rd != '0 && n_q != NW'(RESULT_CAP - 1));
			end
			ST_PPT2: begin
				req.eoc_we = 1'b1;
				req.eoc_wa = cell_addr(fr_q, c_q);
				req.eoc_wd = f_q;
			end
			ST_FIN2: begin
				req.eoc_we = 1'b1;
				req.eoc_wa = cell_addr(fr_q, c_q);
				req.eoc_wd = f_q;
				req.free_we = 1'b1;
				req.free_wa = u_q;
				req.free_wd = fu_q & ~cbit(cu_q);
			end
			ST_FV: begin
				req.free_we = 1'b1;
				req.free_wa = v_q;
				req.free_wd = fv_q & ~cbit(cv_q);
			end
			ST_RW: begin
				req.free_ra_a = w_q;
				req.eoc_ra = cell_addr(w_q, old_c);
			end
			ST_FW: begin
				req.free_we = 1'b1;
				req.free_wa = w_q;
				req.free_wd = fw_m;
				if (f_q != e_q && rsp.eoc_rd == f_q) begin
					req.eoc_we = 1'b1;
					req.eoc_wa = cell_addr(w_q, old_c);
					req.eoc_wd = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			max_degree_q <= 5'd16;
			result_strobe <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_degree_q <= cfg_wdata;
			end
			result_strobe <= emit;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_FREE;
					end
				end
				ST_FREE: begin
					if (fu_m == '0 || fv_m == '0) begin
						state_q <= ST_IDLE;
					end else if (common != '0) begin
						state_q <= ST_COM2;
					end else begin
						state_q <= ST_PRD;
					end
				end
				ST_COM2: state_q <= ST_IDLE;
				ST_PRD: state_q <= ST_PCHK;
				ST_PCHK: begin
					if (rsp.eoc_rd != '0 && n_q != NW'(RESULT_CAP - 1)) begin
						state_q <= ST_PPT2;
					end else begin
						state_q <= ST_FIN2;
					end
				end
				ST_PPT2: state_q <= ST_PRD;
				ST_FIN2: state_q <= ST_FV;
				ST_FV: state_q <= ST_RW;
				ST_RW: state_q <= ST_FW;
				ST_FW: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_edge <= 9'(emit_edge);
			color <= 5'(emit_color);
			last <= emit_last;
			degree_overflow <= emit_ovf;
		end
		case (state_q)
			ST_IDLE: begin
				e_q <= in_e;
				u_q <= in_u;
				v_q <= in_v;
				use_q <= in_use;
			end
			ST_FREE: begin
				fu_q <= rsp.free_rd_a;
				fv_q <= rsp.free_rd_b;
				c_q <= (common != '0) ? c_com : cu_n;
				cu_q <= cu_n;
				cv_q <= cv_n;
				w_q <= v_q;
				f_q <= e_q;
				fl_q <= u_q;
				fr_q <= v_q;
				n_q <= '0;
			end
			ST_PCHK: begin
				ff_q <= rsp.eoc_rd;
			end
			ST_PPT2: begin
				w_q <= w_next;
				fl_q <= lv;
				fr_q <= rv;
				f_q <= ff_q;
				c_q <= c_next;
				n_q <= n_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule
